/* hdl/hft_pkg.sv */
// ----------------------------------------------------------------------------
// hft_pkg
// Shared types, constants and tables of the haptic frame translator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hft_pkg;

  // Default geometry of the command packet.
  localparam int PACKET_BYTES_DEF = 20;
  localparam int MOTOR_COUNT_DEF  = 40;

  // Vest frame layout.
  localparam int          FRAME_LEN   = 20;
  localparam int          FRAME_IDX_W = $clog2(FRAME_LEN);
  localparam logic [7:0]  HDR_MARK    = 8'h68;
  localparam logic [7:0]  TAIL_MARK   = 8'h16;
  localparam logic [15:0] DURATION_MS = 16'd150;
  localparam int          GROUPS      = 4;
  localparam int          PER_GROUP   = 10;
  localparam int          MASK_MOTORS = GROUPS * PER_GROUP;

  // Mask bit of each motor within its group of ten.
  localparam logic [15:0] GROUP_MASK [PER_GROUP] = '{
    16'h8000, 16'h0400, 16'h4000, 16'h0200, 16'h2000,
    16'h0100, 16'h1000, 16'h0080, 16'h0800, 16'h0040
  };

  // Intensity arithmetic: floor(level * gain * 127 / 10000).
  // The division by 10000 is a multiply by ceil(2^34 / 10000) and a shift by
  // 34, which is exact for every dividend below 2^21.
  localparam logic [6:0]  INTENSITY_SCALE = 7'd127;
  localparam int          RECIP_W         = 21;
  localparam logic [RECIP_W-1:0] LEVEL_RECIP = 21'd1717987;
  localparam int          RECIP_SHIFT     = 34;

  // Configuration reset values and limits.
  localparam logic [6:0]  GAIN_RESET      = 7'd100;
  localparam logic [6:0]  GAIN_MAX        = 7'd100;
  localparam logic [15:0] MIN_GAP_RESET   = 16'd35;
  localparam logic [15:0] KEEPALIVE_RESET = 16'd120;

  // Input item kinds.
  typedef enum logic [1:0] {
    CMD_BYTE       = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_DISCONNECT = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GAIN      = 2'd0,
    REG_MIN_GAP   = 2'd1,
    REG_KEEPALIVE = 2'd2
  } cfg_reg_e;

  // Request handed from the scan logic to the frame generator.
  typedef struct packed {
    logic [3:0]                   max_nibble;
    logic [GROUPS-1:0][15:0]      grp;
  } frame_req_t;

  // Motor level floor(nibble * 100 / 15) as a table.
  function automatic logic [6:0] level_of(input logic [3:0] nibble);
    logic [6:0] lvl;
    case (nibble)
      4'd0:    lvl = 7'd0;
      4'd1:    lvl = 7'd6;
      4'd2:    lvl = 7'd13;
      4'd3:    lvl = 7'd20;
      4'd4:    lvl = 7'd26;
      4'd5:    lvl = 7'd33;
      4'd6:    lvl = 7'd40;
      4'd7:    lvl = 7'd46;
      4'd8:    lvl = 7'd53;
      4'd9:    lvl = 7'd60;
      4'd10:   lvl = 7'd66;
      4'd11:   lvl = 7'd73;
      4'd12:   lvl = 7'd80;
      4'd13:   lvl = 7'd86;
      4'd14:   lvl = 7'd93;
      default: lvl = 7'd100;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

/* hdl/hft_frame_gen.sv */
// ----------------------------------------------------------------------------
// hft_frame_gen
// Works out the frame intensity by multiplying the level by the gain, then
// by 127, then by a scaled reciprocal of 10000, and sends the 20 frame
// bytes through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hft_frame_gen
  import hft_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  frame_req_t      req_i,
  input  wire logic [6:0] gain_i,
  output logic            busy_o,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] frame_byte
  output logic            m_axis_tlast    // frame_end
);

  localparam int REM_W   = 21;
  localparam int RPROD_W = REM_W + RECIP_W;

  typedef enum logic [2:0] {
    G_IDLE,
    G_MUL1,
    G_MUL2,
    G_DIV,
    G_EMIT
  } gen_state_e;

  gen_state_e              state_q;
  logic [3:0]              maxn_q;
  logic [GROUPS-1:0][15:0] grp_q;
  logic [13:0]             prod_q;
  logic [REM_W-1:0]        rem_q;
  logic [6:0]              quo_q;
  logic [FRAME_IDX_W-1:0]  idx_q;
  logic                    out_valid_q;
  logic [7:0]              out_data_q;
  logic                    out_last_q;

  logic [RPROD_W-1:0]      recip_prod;
  logic                    load_out;

  // Byte of the frame at a given position.
  function automatic logic [7:0] frame_byte(input logic [FRAME_IDX_W-1:0] idx,
                                            input logic [6:0] inten,
                                            input logic [GROUPS-1:0][15:0] grp);
    logic [7:0] b;
    case (idx) inside
      5'd0, 5'd1:       b = HDR_MARK;
      5'd2, 5'd3:       b = 8'h01;
      5'd7:             b = DURATION_MS[15:8];
      5'd8:             b = DURATION_MS[7:0];
      5'd9, 5'd10:      b = {1'b0, inten};
      5'd11:            b = grp[0][15:8];
      5'd12:            b = grp[0][7:0];
      5'd13:            b = grp[1][15:8];
      5'd14:            b = grp[1][7:0];
      5'd15:            b = grp[2][15:8];
      5'd16:            b = grp[2][7:0];
      5'd17:            b = grp[3][15:8];
      5'd18:            b = grp[3][7:0];
      5'd19:            b = TAIL_MARK;
      default:          b = 8'h00;
    endcase
    return b;
  endfunction

  // Scaled level times the reciprocal of the divisor; the quotient sits above
  // the shift point.
  assign recip_prod = RPROD_W'(rem_q) * RPROD_W'(LEVEL_RECIP);
  assign load_out   = (state_q == G_EMIT) && (!out_valid_q || m_axis_tready);

  // Sequencer, arithmetic and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= G_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        G_IDLE: begin
          if (start_i) begin
            maxn_q  <= req_i.max_nibble;
            grp_q   <= req_i.grp;
            state_q <= G_MUL1;
          end
        end
        G_MUL1: begin
          prod_q  <= 14'(level_of(maxn_q)) * 14'(gain_i);
          state_q <= G_MUL2;
        end
        G_MUL2: begin
          rem_q   <= REM_W'(prod_q) * REM_W'(INTENSITY_SCALE);
          state_q <= G_DIV;
        end
        G_DIV: begin
          // Divide by 10000 through the reciprocal product.
          quo_q   <= recip_prod[RECIP_SHIFT +: 7];
          idx_q   <= '0;
          state_q <= G_EMIT;
        end
        G_EMIT: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            out_data_q  <= frame_byte(idx_q, quo_q, grp_q);
            out_last_q  <= (idx_q == FRAME_IDX_W'(FRAME_LEN - 1));
            if (idx_q == FRAME_IDX_W'(FRAME_LEN - 1)) begin
              state_q <= G_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  assign busy_o        = (state_q != G_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

/* hdl/haptic_frame_translator_core.sv */
// ----------------------------------------------------------------------------
// haptic_frame_translator_core
// Packet bytes and host disconnects are taken in the idle state without a stall.
// A tick that finds data pending, the link up and the gap elapsed scans the
// stored bytes at one per cycle through the two memory read ports.
// A send multiplies out the intensity before the first of 20 frame bytes, then
// one byte a cycle as the sink accepts them; input waits until the last is loaded.
// Asynchronous reset clears all control state and the entry valid bits at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module haptic_frame_translator_core
  import hft_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int MOTOR_COUNT  = MOTOR_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] packet_byte, [8] link_up
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] command
  input  wire logic        s_axis_tlast,  // packet_end
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] frame_byte
  output logic             m_axis_tlast,  // frame_end
  // Configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int HALF_MOTORS = (MOTOR_COUNT + 1) / 2;
  localparam int NB     = (PACKET_BYTES < HALF_MOTORS) ? PACKET_BYTES : HALF_MOTORS;
  localparam int WP_W   = $clog2(PACKET_BYTES + 1);
  localparam int IDX_W  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int CNT_W  = $clog2(NB + 1);
  localparam int BANKS  = 3;

  typedef logic [1:0] bank_t;
  localparam bank_t BANK_SUM = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DECIDE
  } state_e;

  // Three banks hold the staging, current and sent byte sets by role.
  logic [7:0] pkt_mem [BANKS][PACKET_BYTES];
  logic [BANKS-1:0][PACKET_BYTES-1:0] vld_q;

  state_e                  state_q;
  bank_t                   stg_bank_q;
  bank_t                   cur_bank_q;
  bank_t                   snt_bank_q;
  logic [WP_W-1:0]         wp_q;
  logic                    pending_q;
  logic [15:0]             since_q;
  logic [6:0]              gain_q;
  logic [15:0]             min_gap_q;
  logic [15:0]             keepalive_q;

  logic [CNT_W-1:0]        walk_cnt_q;
  logic                    rd_vld_q;
  logic [CNT_W-1:0]        rd_idx_q;
  logic [7:0]              rd_c_q;
  logic [7:0]              rd_t_q;
  logic                    vc_q;
  logic                    vt_q;
  logic                    chg_q;
  logic                    nz_q;
  logic [3:0]              maxn_q;
  logic [MASK_MOTORS-1:0]  act_q;

  logic                    in_fire;
  cmd_e                    cmd;
  logic [7:0]              pkt_byte;
  logic                    link_up;
  logic                    mem_we;
  logic [IDX_W-1:0]        wr_idx;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  bank_t                   free_bank;
  logic [15:0]             since_d;
  logic                    tick_go;

  logic [7:0]              cd;
  logic [7:0]              td;
  logic [6:0]              lo_motor;
  logic                    lo_ok;
  logic [3:0]              hi_c, lo_c, hi_t, lo_t;
  logic                    byte_chg;
  logic                    byte_nz;
  logic [3:0]              byte_max;
  logic [MASK_MOTORS-1:0]  act_set;
  logic                    send_ok;
  frame_req_t              req;
  logic                    gen_start;
  logic                    gen_busy;

  // Input decode.
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cmd      = cmd_e'(s_axis_tuser);
  assign pkt_byte = s_axis_tdata[7:0];
  assign link_up  = s_axis_tdata[8];

  assign s_axis_tready = (state_q == ST_IDLE) && !gen_busy;
  assign cfg_ready_o   = 1'b1;

  // Staging write and scan read addresses.
  assign mem_we    = in_fire && (cmd == CMD_BYTE) && (wp_q < WP_W'(PACKET_BYTES));
  assign wr_idx    = wp_q[IDX_W-1:0];
  assign rd_en     = (state_q == ST_WALK) && (walk_cnt_q < CNT_W'(NB));
  assign rd_addr   = IDX_W'(walk_cnt_q);
  assign free_bank = BANK_SUM - stg_bank_q - snt_bank_q;

  // Saturating millisecond count and send gate for a tick.
  assign since_d = (since_q == 16'hFFFF) ? since_q : since_q + 16'd1;
  assign tick_go = link_up && pending_q && (since_d >= min_gap_q);

  // Byte memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pkt_mem[stg_bank_q][wr_idx] <= pkt_byte;
    end
    if (rd_en) begin
      rd_c_q <= pkt_mem[cur_bank_q][rd_addr];
      rd_t_q <= pkt_mem[snt_bank_q][rd_addr];
    end
  end

  // Per-byte comparison of current against sent nibbles.
  always_comb begin
    cd       = vc_q ? rd_c_q : 8'h00;
    td       = vt_q ? rd_t_q : 8'h00;
    lo_motor = 7'({rd_idx_q, 1'b1});
    lo_ok    = (lo_motor < 7'(MOTOR_COUNT));
    hi_c     = cd[7:4];
    hi_t     = td[7:4];
    lo_c     = lo_ok ? cd[3:0] : 4'h0;
    lo_t     = lo_ok ? td[3:0] : 4'h0;
    byte_chg = (hi_c != hi_t) || (lo_c != lo_t);
    byte_nz  = (hi_c != 4'h0) || (lo_c != 4'h0);
    byte_max = (hi_c > lo_c) ? hi_c : lo_c;
    for (int m = 0; m < MASK_MOTORS; m++) begin
      act_set[m] = rd_vld_q && (rd_idx_q == (m >> 1)) &&
                   (((m & 1) == 0) ? (hi_c != 4'h0) : (lo_c != 4'h0));
    end
  end

  // Group masks from the active motors.
  always_comb begin
    req.max_nibble = maxn_q;
    for (int g = 0; g < GROUPS; g++) begin
      req.grp[g] = 16'h0000;
      for (int k = 0; k < PER_GROUP; k++) begin
        if (act_q[g * PER_GROUP + k]) begin
          req.grp[g] = req.grp[g] | GROUP_MASK[k];
        end
      end
    end
  end

  assign send_ok   = chg_q || (nz_q && (since_q >= keepalive_q));
  assign gen_start = (state_q == ST_DECIDE) && send_ok;

  // Control state, roles of the banks and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stg_bank_q  <= 2'd1;
      cur_bank_q  <= 2'd0;
      snt_bank_q  <= 2'd0;
      vld_q       <= '0;
      wp_q        <= '0;
      pending_q   <= 1'b0;
      since_q     <= '0;
      gain_q      <= GAIN_RESET;
      min_gap_q   <= MIN_GAP_RESET;
      keepalive_q <= KEEPALIVE_RESET;
      walk_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      vc_q        <= 1'b0;
      vt_q        <= 1'b0;
      chg_q       <= 1'b0;
      nz_q        <= 1'b0;
      maxn_q      <= '0;
      act_q       <= '0;
    end else begin
      // Configuration transaction.
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_GAIN: begin
            gain_q <= (cfg_data_i > 16'(GAIN_MAX)) ? GAIN_MAX : cfg_data_i[6:0];
          end
          REG_MIN_GAP:   min_gap_q   <= cfg_data_i;
          REG_KEEPALIVE: keepalive_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (mem_we) begin
        vld_q[stg_bank_q][wr_idx] <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (cmd)
              CMD_BYTE: begin
                if (mem_we) begin
                  wp_q <= wp_q + 1'b1;
                end
                // End of packet: staging becomes current, a clean bank stages.
                if (s_axis_tlast) begin
                  cur_bank_q        <= stg_bank_q;
                  stg_bank_q        <= free_bank;
                  vld_q[free_bank]  <= '0;
                  wp_q              <= '0;
                  pending_q         <= 1'b1;
                end
              end
              CMD_DISCONNECT: begin
                cur_bank_q        <= stg_bank_q;
                stg_bank_q        <= free_bank;
                vld_q[stg_bank_q] <= '0;
                vld_q[free_bank]  <= '0;
                wp_q              <= '0;
                pending_q         <= 1'b1;
              end
              CMD_TICK: begin
                since_q <= since_d;
                if (tick_go) begin
                  pending_q  <= 1'b0;
                  walk_cnt_q <= '0;
                  chg_q      <= 1'b0;
                  nz_q       <= 1'b0;
                  maxn_q     <= '0;
                  act_q      <= '0;
                  state_q    <= ST_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          // Issue one address a cycle, fold in the byte read the cycle before.
          if (rd_en) begin
            rd_vld_q   <= 1'b1;
            rd_idx_q   <= walk_cnt_q;
            vc_q       <= vld_q[cur_bank_q][rd_addr];
            vt_q       <= vld_q[snt_bank_q][rd_addr];
            walk_cnt_q <= walk_cnt_q + 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
            state_q  <= ST_DECIDE;
          end
          if (rd_vld_q) begin
            chg_q  <= chg_q | byte_chg;
            nz_q   <= nz_q | byte_nz;
            maxn_q <= (byte_max > maxn_q) ? byte_max : maxn_q;
            act_q  <= act_q | act_set;
          end
        end
        ST_DECIDE: begin
          // The sent set now aliases the current bank.
          if (send_ok) begin
            snt_bank_q <= cur_bank_q;
            since_q    <= '0;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  hft_frame_gen u_frame_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (gen_start),
    .req_i         (req),
    .gain_i        (gain_q),
    .busy_o        (gen_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* hdl/hft_checker.sv */
// ----------------------------------------------------------------------------
// hft_checker
// Port-level checks on the frame stream of the translator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hft_checker
  import hft_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [15:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [1:0]  cfg_index_i,
  input wire logic [15:0] cfg_data_i
);

  logic [FRAME_IDX_W-1:0] beat_q;
  logic                   out_fire;

  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Position of the next frame byte on the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (out_fire) begin
      beat_q <= m_axis_tlast ? '0 : beat_q + 1'b1;
    end
  end

  // Frames are exactly twenty bytes long.
  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (m_axis_tlast == (beat_q == FRAME_IDX_W'(FRAME_LEN - 1))))
    else $error("frame end does not fall on the twentieth byte");

  // Every frame opens with the header mark.
  a_frame_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (beat_q == '0)) |-> (m_axis_tdata == HDR_MARK))
    else $error("frame does not open with the header mark");

  // Every frame closes with the tail mark.
  a_frame_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast) |-> (m_axis_tdata == TAIL_MARK))
    else $error("frame does not close with the tail mark");

  // No input is taken while the middle of a frame is still being produced.
  a_busy_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((beat_q != '0) && (beat_q != FRAME_IDX_W'(FRAME_LEN - 1))) |-> !s_axis_tready)
    else $error("input accepted in the middle of a frame");

  // A stalled output byte holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output byte changed");

endmodule

bind haptic_frame_translator_core hft_checker u_hft_checker (.*);

`default_nettype wire

/* tb/haptic_frame_translator_core_tb.sv */
// ----------------------------------------------------------------------------
// haptic_frame_translator_core_tb
// Self-checking bench for the haptic command to vest frame translator.
// A queue-fed driver offers packet bytes, ticks and disconnects on the input
// stream while a monitor checks every frame byte against a predictor that
// keeps its own copy of the staging, committed and last-sent motor sets.
// Both stream sides idle at random, and one long sink hold-off makes the
// block fill up and stall its input. Configuration changes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haptic_frame_translator_core_tb;
  import hft_pkg::*;

  localparam int PKT_BYTES     = 20;
  localparam int MOTORS        = 40;
  localparam int MASK_GROUPS   = 4;
  localparam int GROUP_SIZE    = 10;
  localparam int VEST_LEN      = 20;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 2000000;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam logic [1:0] REG_SPARE    = 2'd3;

  // Vest frame layout.
  localparam logic [7:0]  VEST_HDR   = 8'h68;
  localparam logic [7:0]  VEST_TAIL  = 8'h16;
  localparam logic [15:0] VEST_DUR   = 16'd150;
  localparam logic [15:0] MOTOR_MASK [GROUP_SIZE] = '{
    16'h8000, 16'h0400, 16'h4000, 16'h0200, 16'h2000,
    16'h0100, 16'h1000, 16'h0080, 16'h0800, 16'h0040
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pb;
    logic       pend;
    logic       link;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } vest_byte_t;

  // Clock, reset and block ports.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  // Stimulus and expectation stores.
  cmd_item_t  cmd_q [$];
  vest_byte_t vest_q [$];

  // Predictor state and configuration.
  logic [PKT_BYTES-1:0][7:0] staged    = '0;
  logic [PKT_BYTES-1:0][7:0] committed = '0;
  logic [PKT_BYTES-1:0][7:0] last_sent = '0;
  int unsigned               wr_pos    = 0;
  logic                      pending   = 1'b0;
  logic [15:0]               since_ms  = '0;
  int unsigned               gain_pct  = 100;
  logic [15:0]               min_gap   = 16'd35;
  logic [15:0]               keepalive = 16'd120;

  // Run control.
  logic src_idle_en   = 1'b0;
  logic sink_idle_en  = 1'b0;
  int   pressure_req  = 0;
  int   pressure_ack  = 0;
  int   sink_hold     = 0;
  int   sink_stall    = 0;
  int   src_gap       = 0;
  int   err_count     = 0;
  int   items_taken   = 0;
  int   bytes_seen    = 0;
  int   frames_seen   = 0;
  int   phases_run    = 0;
  int   cycle_count   = 0;

  haptic_frame_translator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Idle spans: mostly none or short, now and then long.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [3:0] motor_nibble(input logic [PKT_BYTES-1:0][7:0] bytes,
                                              input int m);
    if (m / 2 >= PKT_BYTES) return 4'd0;
    return m[0] ? bytes[m/2][3:0] : bytes[m/2][7:4];
  endfunction

  // Works out the frame bytes, if any, that one accepted input item causes.
  function automatic void translate_item(input cmd_item_t it);
    int unsigned                lvl;
    int unsigned                max_lvl;
    int unsigned                inten;
    logic [MASK_GROUPS-1:0][15:0] grp;
    logic                       changed;
    logic                       nonzero;
    logic [VEST_LEN-1:0][7:0]   fr;
    vest_byte_t                 vb;
    changed = 1'b0;
    nonzero = 1'b0;
    max_lvl = 0;
    grp     = '0;
    case (it.cmd)
      CMD_BYTE: begin
        if (wr_pos < PKT_BYTES) begin
          staged[wr_pos] = it.pb;
          wr_pos++;
        end
        if (it.pend) begin
          committed = staged;
          staged    = '0;
          wr_pos    = 0;
          pending   = 1'b1;
        end
      end
      CMD_DISCONNECT: begin
        committed = '0;
        staged    = '0;
        wr_pos    = 0;
        pending   = 1'b1;
      end
      CMD_TICK: begin
        if (since_ms != 16'hFFFF) since_ms++;
        if (it.link && pending && since_ms >= min_gap) begin
          for (int m = 0; m < MOTORS; m++) begin
            if (motor_nibble(committed, m) != motor_nibble(last_sent, m)) changed = 1'b1;
            if (motor_nibble(committed, m) != 4'd0) nonzero = 1'b1;
          end
          pending = 1'b0;
          if (changed || (nonzero && since_ms >= keepalive)) begin
            last_sent = committed;
            since_ms  = '0;
            for (int m = 0; m < MOTORS; m++) begin
              lvl = motor_nibble(committed, m) * 100 / 15;
              if (lvl > max_lvl) max_lvl = lvl;
              if (lvl > 0 && m / GROUP_SIZE < MASK_GROUPS)
                grp[m/GROUP_SIZE] |= MOTOR_MASK[m%GROUP_SIZE];
            end
            inten = max_lvl * gain_pct * 127 / 10000;
            if (inten > 255) inten = 255;
            fr[0]  = VEST_HDR;
            fr[1]  = VEST_HDR;
            fr[2]  = 8'h01;
            fr[3]  = 8'h01;
            fr[4]  = 8'h00;
            fr[5]  = 8'h00;
            fr[6]  = 8'h00;
            fr[7]  = VEST_DUR[15:8];
            fr[8]  = VEST_DUR[7:0];
            fr[9]  = inten[7:0];
            fr[10] = inten[7:0];
            for (int g = 0; g < MASK_GROUPS; g++) begin
              fr[11+2*g] = grp[g][15:8];
              fr[12+2*g] = grp[g][7:0];
            end
            fr[19] = VEST_TAIL;
            for (int i = 0; i < VEST_LEN; i++) begin
              vb.frame_byte = fr[i];
              vb.frame_end  = (i == VEST_LEN - 1);
              vest_q.push_back(vb);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Input stream driver, fed from the command queue.
  always @(posedge clk_i or negedge rst_ni) begin : cmd_drive
    cmd_item_t nxt;
    cmd_item_t seen;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen.cmd  = s_axis_tuser;
        seen.pb   = s_axis_tdata[7:0];
        seen.pend = s_axis_tlast;
        seen.link = s_axis_tdata[8];
        translate_item(seen);
        items_taken++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // Offer stays up until the transaction completes.
      end else if (src_gap != 0) begin
        src_gap       <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        nxt = cmd_q.pop_front();
        s_axis_tdata  <= {7'd0, nxt.link, nxt.pb};
        s_axis_tuser  <= nxt.cmd;
        s_axis_tlast  <= nxt.pend;
        s_axis_tvalid <= 1'b1;
        src_gap       <= src_idle_en ? idle_span() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output stream readiness: random stalls plus the long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      pressure_ack  <= 0;
      sink_hold     <= 0;
      sink_stall    <= 0;
    end else if (pressure_ack != pressure_req) begin
      pressure_ack  <= pressure_req;
      sink_hold     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall    <= sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
      sink_stall    <= idle_span();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Frame byte monitor.
  always @(posedge clk_i) begin : vest_check
    vest_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (vest_q.size() == 0) begin
        $error("unexpected frame byte: actual %02h", m_axis_tdata);
        err_count++;
      end else begin
        want = vest_q.pop_front();
        if (m_axis_tdata !== want.frame_byte) begin
          $error("frame_byte: expected %02h, actual %02h", want.frame_byte, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tlast !== want.frame_end) begin
          $error("frame_end: expected %0b, actual %0b", want.frame_end, m_axis_tlast);
          err_count++;
        end
      end
      bytes_seen++;
      if (m_axis_tlast) frames_seen++;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] pb,
                            input logic pend, input logic link);
    cmd_item_t it;
    it.cmd  = cmd;
    it.pb   = pb;
    it.pend = pend;
    it.link = link;
    cmd_q.push_back(it);
  endtask

  // One register write transaction; the predictor follows at the handshake.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_GAIN:      gain_pct  = (val > 100) ? 100 : val;
      REG_MIN_GAP:   min_gap   = val;
      REG_KEEPALIVE: keepalive = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] gain, input logic [15:0] gap,
                            input logic [15:0] keep);
    write_reg(REG_GAIN, gain);
    write_reg(REG_MIN_GAP, gap);
    write_reg(REG_KEEPALIVE, keep);
    phases_run++;
  endtask

  // Waits until all items are taken and all frames are out, then lets a
  // silent tick scan finish before anything else happens.
  task automatic settle();
    do @(posedge clk_i); while (cmd_q.size() != 0 || s_axis_tvalid);
    do @(posedge clk_i); while (vest_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] motor_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) return 8'h00;
    if (r == 2) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly whole packets followed by ticks; the rest is noise.
  task automatic random_traffic(input int n);
    int         pushed;
    int         len;
    int         r;
    int         prev_len;
    logic [7:0] prev_pkt [24];
    logic [7:0] b;
    logic       again;
    pushed   = 0;
    prev_len = 0;
    while (pushed < n) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        again = (prev_len != 0) && ($urandom_range(0, 3) == 0);
        if (!again) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 24) : $urandom_range(1, 20);
          prev_len = len;
        end
        for (int i = 0; i < prev_len; i++) begin
          if (!again) prev_pkt[i] = motor_byte();
          b = prev_pkt[i];
          queue_item(CMD_BYTE, b, i == prev_len - 1, 1'($urandom_range(0, 1)));
          pushed++;
        end
        repeat ($urandom_range(1, 3)) begin
          queue_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 7) != 0);
          pushed++;
        end
      end else if (r < 83) begin
        queue_item(CMD_DISCONNECT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        pushed++;
      end else if (r < 90) begin
        queue_item(CMD_RESERVED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else begin
        queue_item($urandom_range(0, 1) ? CMD_BYTE : CMD_TICK, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        pushed++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: gap of two ticks, keepalive of four, full gain.
    write_reg(REG_SPARE, 16'hFFFF);
    set_config(16'd100, 16'd2, 16'd4);
    src_idle_en  <= 1'b1;
    sink_idle_en <= 1'b1;
    queue_item(CMD_BYTE, 8'hF0, 1'b0, 1'b0);
    queue_item(CMD_BYTE, 8'h0F, 1'b1, 1'b1);
    queue_item(CMD_TICK, 8'h00, 1'b0, 1'b1);        // gap not yet elapsed
    queue_item(CMD_TICK, 8'hFF, 1'b1, 1'b0);        // link down keeps data pending
    queue_item(CMD_TICK, 8'h00, 1'b0, 1'b1);        // first frame
    queue_item(CMD_BYTE, 8'hAB, 1'b1, 1'b0);        // single-byte packet
    queue_item(CMD_BYTE, 8'h12, 1'b0, 1'b1);
    queue_item(CMD_DISCONNECT, 8'hFF, 1'b1, 1'b1);  // drops the partial packet
    queue_item(CMD_TICK, 8'h5A, 1'b0, 1'b1);
    queue_item(CMD_TICK, 8'hA5, 1'b1, 1'b1);        // all-zero frame
    queue_item(CMD_RESERVED, 8'hFF, 1'b1, 1'b1);    // unknown command
    queue_item(CMD_TICK, 8'h00, 1'b0, 1'b1);        // nothing pending
    queue_item(CMD_BYTE, 8'h55, 1'b1, 1'b0);
    queue_item(CMD_TICK, 8'h00, 1'b0, 1'b1);
    queue_item(CMD_BYTE, 8'h55, 1'b1, 1'b0);
    queue_item(CMD_TICK, 8'h00, 1'b0, 1'b1);
    queue_item(CMD_TICK, 8'h00, 1'b0, 1'b1);        // unchanged, pending cleared
    queue_item(CMD_BYTE, 8'h55, 1'b1, 1'b0);
    queue_item(CMD_TICK, 8'h00, 1'b0, 1'b1);
    queue_item(CMD_BYTE, 8'h55, 1'b1, 1'b0);
    queue_item(CMD_TICK, 8'h00, 1'b0, 1'b1);        // keepalive resend
    settle();

    // Clamped gain, no gap, immediate keepalive.
    set_config(16'hFFFF, 16'd0, 16'd0);
    random_traffic(50);
    settle();

    // Zero gain and no keepalive, with both sides running flat out.
    set_config(16'd0, 16'd1, 16'hFFFF);
    src_idle_en  <= 1'b0;
    sink_idle_en <= 1'b0;
    random_traffic(45);
    settle();

    // Mid-range settings with idling back on.
    set_config(16'($urandom_range(1, 99)), 16'($urandom_range(0, 3)),
               16'($urandom_range(0, 10)));
    src_idle_en  <= 1'b1;
    sink_idle_en <= 1'b1;
    random_traffic(60);
    settle();

    // Long sink hold-off while ticks keep bringing frames.
    set_config(16'd50, 16'd0, 16'd0);
    src_idle_en  <= 1'b0;
    pressure_req <= pressure_req + 1;
    repeat (12) begin
      queue_item(CMD_BYTE, motor_byte(), 1'b1, 1'b1);
      queue_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    settle();

    // Largest gap: nothing may be sent.
    set_config(16'd101, 16'hFFFF, 16'd6);
    src_idle_en <= 1'b1;
    random_traffic(20);
    settle();

    // Short gap and keepalive once more.
    set_config(16'd127, 16'd3, 16'd6);
    random_traffic(30);
    settle();

    if (vest_q.size() != 0) $error("%0d frame bytes never arrived", vest_q.size());
    $display("Run covered %0d input transactions over %0d configuration phases.",
             items_taken, phases_run);
    $display("Checked %0d frame bytes in %0d vest frames, with one long sink hold-off.",
             bytes_seen, frames_seen);
    if (err_count == 0 && vest_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
